### hdl/tqps_pkg.sv
// Shared types and codes for the three-queue process state table.
`timescale 1ns / 1ps
`default_nettype none

package tqps_pkg;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_JOIN   = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  // Queue selector codes; the remaining code selects no queue.
  localparam logic [1:0] QSEL_RUNNING = 2'd0;
  localparam logic [1:0] QSEL_READY   = 2'd1;
  localparam logic [1:0] QSEL_WAIT    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] queue_select;
    logic [7:0] proc_id;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic       done_res;
    logic       already_present;
    logic       queue_full;
    logic [7:0] running_head;
    logic       running_valid;
    logic [7:0] ready_head;
    logic       ready_valid;
    logic [4:0] running_count;
    logic [4:0] ready_count;
    logic [4:0] wait_count;
  } res_t;

  // Operation strobes for one queue.
  typedef struct packed {
    logic join_op;
    logic remove_op;
    logic pop_op;
  } q_ctl_t;

  // Search outcome of one queue.
  typedef struct packed {
    logic present;
    logic full;
  } q_flags_t;

  // Broadcast controls seen by every cell of a queue.
  typedef struct packed {
    logic wr;
    logic pop_op;
    logic remove_op;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/tqps_cell.sv
// One queue slot: holds an ID, compares it and takes its right neighbour's ID on a shift.
`timescale 1ns / 1ps
`default_nettype none

module tqps_cell #(
  parameter int ID_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire tqps_pkg::cell_ctl_t  ctl_i,
  input  wire logic [ID_BITS-1:0]   id_i,
  input  wire logic                 valid_i,
  input  wire logic                 tail_i,
  input  wire logic                 hit_i,
  input  wire logic [ID_BITS-1:0]   next_i,
  output logic      [ID_BITS-1:0]   entry_o,
  output logic                      hit_o
);

  logic [ID_BITS-1:0] entry_q, entry_d;
  logic               match;
  logic               shift;

  assign match = valid_i && (entry_q == id_i);
  assign hit_o = hit_i | match;
  // A removal closes the gap from the matching slot onwards.
  assign shift = ctl_i.pop_op | (ctl_i.remove_op & hit_o);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.wr && tail_i) begin
      entry_d = id_i;
    end else if (shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### hdl/tqps_queue.sv
// One bounded FIFO of IDs built as a chain of cells with its fill count.
`timescale 1ns / 1ps
`default_nettype none

module tqps_queue #(
  parameter  int DEPTH   = 16,
  parameter  int ID_BITS = 8,
  localparam int LEN_W   = $clog2(DEPTH + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tqps_pkg::q_ctl_t   ctl_i,
  input  wire logic [ID_BITS-1:0] id_i,
  output tqps_pkg::q_flags_t      flags_o,
  output logic      [LEN_W-1:0]   len_o,
  output logic      [ID_BITS-1:0] head_o
);

  logic [LEN_W-1:0]   len_q, len_d;
  logic [ID_BITS-1:0] entry [DEPTH];
  logic [DEPTH:0]     hit_chain;
  logic               present;
  logic               full;
  tqps_pkg::cell_ctl_t cell_ctl;

  assign hit_chain[0] = 1'b0;
  assign present      = hit_chain[DEPTH];
  assign full         = (len_q == LEN_W'(DEPTH));

  assign cell_ctl.wr        = ctl_i.join_op & ~present & ~full;
  assign cell_ctl.pop_op    = ctl_i.pop_op;
  assign cell_ctl.remove_op = ctl_i.remove_op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] next;
    if (i < DEPTH - 1) begin : g_mid
      assign next = entry[i+1];
    end else begin : g_end
      assign next = '0;
    end
    tqps_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .id_i   (id_i),
      .valid_i(LEN_W'(i) < len_q),
      .tail_i (LEN_W'(i) == len_q),
      .hit_i  (hit_chain[i]),
      .next_i (next),
      .entry_o(entry[i]),
      .hit_o  (hit_chain[i+1])
    );
  end

  always_comb begin
    len_d = len_q;
    if (cell_ctl.wr) begin
      len_d = len_q + LEN_W'(1);
    end else if (ctl_i.remove_op && present) begin
      len_d = len_q - LEN_W'(1);
    end else if (ctl_i.pop_op && (len_q != '0)) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign flags_o.present = present;
  assign flags_o.full    = full;
  assign len_o           = len_q;
  assign head_o          = entry[0];

endmodule

`default_nettype wire

### hdl/three_queue_process_state_table.sv
// Top level of the three-queue process state table: running, ready and wait queues.
// After the edge that accepts a command the controller passes through execute; the result
// strobe is high in report. The execute cycle holds busy, and the next command is accepted
// during the report cycle, while the last result is shown. Each command is a single cell-chain update pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the three counts and the controller; queue slots are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module three_queue_process_state_table #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire tqps_pkg::cmd_t cmd_i,
  output logic                res_valid_o,
  output tqps_pkg::res_t      res_o
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  // The controller walks idle, execute and report. A command is captured when start
  // is seen while busy is low; the execute cycle drives the cell chains, which update
  // their slots and counts at its closing edge. The report cycle then shows the
  // result built from the updated state, and a new command may be taken in that cycle.
  tqps_pkg::state_e state_q, state_d;
  tqps_pkg::cmd_t   cmd_q;
  logic             accept;

  // Outcome flags of the executed command, held for the report cycle.
  logic done_q, present_q, full_q;
  logic done_d, present_d, full_d;

  tqps_pkg::q_ctl_t   run_ctl, rdy_ctl, wt_ctl;
  tqps_pkg::q_flags_t run_flags, rdy_flags, wt_flags, sel_flags;
  logic [LEN_W-1:0]   run_len, rdy_len, wt_len;
  logic [ID_BITS-1:0] run_head, rdy_head;
  logic [ID_BITS-1:0] id;
  logic [ID_BITS+7:0] id_ext;
  logic [ID_BITS+7:0] run_head_ext, rdy_head_ext;
  logic [LEN_W+4:0]   run_cnt_ext, rdy_cnt_ext, wt_cnt_ext;
  logic               join_cmd, remove_cmd;

  assign accept = start & ~busy;

  // Only the low ID_BITS bits of the process ID take part.
  assign id_ext = {{ID_BITS{1'b0}}, cmd_q.proc_id};
  assign id     = id_ext[ID_BITS-1:0];

  always_comb begin
    state_d     = state_q;
    busy        = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      tqps_pkg::ST_IDLE: begin
        if (start) begin
          state_d = tqps_pkg::ST_EXEC;
        end
      end
      tqps_pkg::ST_EXEC: begin
        busy    = 1'b1;
        state_d = tqps_pkg::ST_REPORT;
      end
      tqps_pkg::ST_REPORT: begin
        res_valid_o = 1'b1;
        state_d     = start ? tqps_pkg::ST_EXEC : tqps_pkg::ST_IDLE;
      end
      default: begin
        state_d = tqps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tqps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  // Command decode. Strobes reach the queues only in the execute cycle; a pop always
  // targets the running queue, and a selector naming no queue drives no join or removal.
  always_comb begin
    join_cmd   = 1'b0;
    remove_cmd = 1'b0;
    run_ctl    = '0;
    rdy_ctl    = '0;
    wt_ctl     = '0;
    if (busy) begin
      unique case (tqps_pkg::func_e'(cmd_q.func))
        tqps_pkg::FUNC_JOIN:   join_cmd   = 1'b1;
        tqps_pkg::FUNC_REMOVE: remove_cmd = 1'b1;
        tqps_pkg::FUNC_POP:    run_ctl.pop_op = 1'b1;
        tqps_pkg::FUNC_QUERY:  ;
        default:               ;
      endcase
      unique case (cmd_q.queue_select)
        tqps_pkg::QSEL_RUNNING: begin
          run_ctl.join_op   = join_cmd;
          run_ctl.remove_op = remove_cmd;
        end
        tqps_pkg::QSEL_READY: begin
          rdy_ctl.join_op   = join_cmd;
          rdy_ctl.remove_op = remove_cmd;
        end
        tqps_pkg::QSEL_WAIT: begin
          wt_ctl.join_op   = join_cmd;
          wt_ctl.remove_op = remove_cmd;
        end
        default: ;
      endcase
    end
  end

  // The search outcome of the selected queue decides the reported flags.
  always_comb begin
    unique case (cmd_q.queue_select)
      tqps_pkg::QSEL_RUNNING: sel_flags = run_flags;
      tqps_pkg::QSEL_READY:   sel_flags = rdy_flags;
      tqps_pkg::QSEL_WAIT:    sel_flags = wt_flags;
      default:                sel_flags = '0;
    endcase
    if (cmd_q.queue_select == tqps_pkg::QSEL_RUNNING ||
        cmd_q.queue_select == tqps_pkg::QSEL_READY ||
        cmd_q.queue_select == tqps_pkg::QSEL_WAIT) begin
      // A duplicate join reports presence even when the queue is full.
      present_d = join_cmd & sel_flags.present;
      full_d    = join_cmd & ~sel_flags.present & sel_flags.full;
      done_d    = (join_cmd & ~sel_flags.present & ~sel_flags.full) |
                  (remove_cmd & sel_flags.present);
    end else begin
      present_d = 1'b0;
      full_d    = 1'b0;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      done_q    <= done_d;
      present_q <= present_d;
      full_q    <= full_d;
    end
  end

  tqps_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_running (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (run_ctl),
    .id_i   (id),
    .flags_o(run_flags),
    .len_o  (run_len),
    .head_o (run_head)
  );

  tqps_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_ready (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rdy_ctl),
    .id_i   (id),
    .flags_o(rdy_flags),
    .len_o  (rdy_len),
    .head_o (rdy_head)
  );

  tqps_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_wait (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (wt_ctl),
    .id_i   (id),
    .flags_o(wt_flags),
    .len_o  (wt_len),
    .head_o (/* wait head is not reported */)
  );

  // Heads are reported in eight bits and counts in five, zero-extended or cut as needed.
  assign run_head_ext = {8'b0, run_head};
  assign rdy_head_ext = {8'b0, rdy_head};
  assign run_cnt_ext  = {5'b0, run_len};
  assign rdy_cnt_ext  = {5'b0, rdy_len};
  assign wt_cnt_ext   = {5'b0, wt_len};

  always_comb begin
    res_o.done_res        = done_q;
    res_o.already_present = present_q;
    res_o.queue_full      = full_q;
    res_o.running_valid   = (run_len != '0);
    res_o.running_head    = res_o.running_valid ? run_head_ext[7:0] : 8'd0;
    res_o.ready_valid     = (rdy_len != '0);
    res_o.ready_head      = res_o.ready_valid ? rdy_head_ext[7:0] : 8'd0;
    res_o.running_count   = run_cnt_ext[4:0];
    res_o.ready_count     = rdy_cnt_ext[4:0];
    res_o.wait_count      = wt_cnt_ext[4:0];
  end

endmodule

`default_nettype wire
